// ===== rtl/core/seth_pkg.sv =====
// Shared constants, payload types and memory request types of the edge toggle hash.
package seth_pkg;

	localparam int TABLE_SIZE    = 5987;
	localparam int VERTEX_BITS   = 16;
	localparam int PROBE_STEP    = 241;

	// Fixed field widths of the request and result items.
	localparam int SLOT_FIELD_W  = 13;
	localparam int COUNT_FIELD_W = 13;
	localparam int COLL_W        = 32;

	localparam int SLOT_W        = $clog2(TABLE_SIZE);
	localparam int CNT_W         = $clog2(TABLE_SIZE + 1);
	localparam int REM_W         = SLOT_W + 1;
	localparam int STEP_MOD      = PROBE_STEP % TABLE_SIZE;

	// Hash reduction: a*a + b*b folded modulo TABLE_SIZE, RED_BITS bits a cycle.
	localparam int SQ_W          = 2 * VERTEX_BITS;
	localparam int SUM_W         = SQ_W + 1;
	localparam int RED_BITS      = 4;
	localparam int RED_DIGITS    = (SUM_W + RED_BITS - 1) / RED_BITS;
	localparam int RED_PAD       = RED_DIGITS * RED_BITS;
	localparam int DIGIT_CNT_W   = (RED_DIGITS > 1) ? $clog2(RED_DIGITS) : 1;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_TOGGLE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_REMOVED = 3'd1,
		ST_FULL    = 3'd2,
		ST_CLEARED = 3'd3,
		ST_READ    = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t                    command;
		logic [VERTEX_BITS-1:0]  vertex_a;
		logic [VERTEX_BITS-1:0]  vertex_b;
		logic [SLOT_FIELD_W-1:0] slot;
	} edge_req_t;

	typedef struct packed {
		status_t                  status;
		logic                     occupied;
		logic [SLOT_FIELD_W-1:0]  slot_index;
		logic [VERTEX_BITS-1:0]   stored_a;
		logic [VERTEX_BITS-1:0]   stored_b;
		logic [COUNT_FIELD_W-1:0] edge_count;
		logic [COLL_W-1:0]        collision_total;
	} edge_rsp_t;

	typedef struct packed {
		logic                   valid;
		logic [VERTEX_BITS-1:0] first;
		logic [VERTEX_BITS-1:0] second;
	} slot_entry_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [SLOT_W-1:0] addr;
		slot_entry_t       wdata;
	} ram_req_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] key;
	} hash_rsp_t;

endpackage

// ===== rtl/core/seth_slot_ram.sv =====
// Single-port slot table memory with registered read data.
module seth_slot_ram (
	input  logic                 clk,
	input  seth_pkg::ram_req_t   req,
	output seth_pkg::slot_entry_t rd_data
);
	import seth_pkg::*;

	slot_entry_t slots_q [TABLE_SIZE];
	slot_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			slots_q[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_data_q <= slots_q[req.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/seth_hash.sv =====
// Home slot hash: (a*a + b*b) mod TABLE_SIZE, squares then digit-serial reduction.
module seth_hash (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [seth_pkg::VERTEX_BITS-1:0] vertex_a,
	input  logic [seth_pkg::VERTEX_BITS-1:0] vertex_b,
	output seth_pkg::hash_rsp_t              rsp
);
	import seth_pkg::*;

	typedef enum logic [2:0] {
		H_IDLE   = 3'b001,
		H_SUM    = 3'b010,
		H_REDUCE = 3'b100
	} hstate_t;

	hstate_t                state_q;
	logic [SQ_W-1:0]        sq_a_q;
	logic [SQ_W-1:0]        sq_b_q;
	logic [RED_PAD-1:0]     x_q;
	logic [SLOT_W-1:0]      rem_q;
	logic [DIGIT_CNT_W-1:0] digit_q;
	logic                   done_q;
	logic [SLOT_W-1:0]      rem_next;

	// RED_BITS restoring steps, MSB first; remainder stays below TABLE_SIZE
	always_comb begin
		logic [REM_W-1:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < RED_BITS; i++) begin
			r = {r[SLOT_W-1:0], x_q[RED_PAD-1-i]};
			if (r >= REM_W'(TABLE_SIZE)) begin
				r = r - REM_W'(TABLE_SIZE);
			end
		end
		rem_next = r[SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			digit_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						state_q <= H_SUM;
					end
				end
				H_SUM: begin
					digit_q <= '0;
					state_q <= H_REDUCE;
				end
				H_REDUCE: begin
					digit_q <= digit_q + 1'b1;
					if (digit_q == DIGIT_CNT_W'(RED_DIGITS - 1)) begin
						done_q  <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == H_IDLE && start) begin
			sq_a_q <= SQ_W'(vertex_a) * SQ_W'(vertex_a);
			sq_b_q <= SQ_W'(vertex_b) * SQ_W'(vertex_b);
		end
		if (state_q == H_SUM) begin
			x_q   <= RED_PAD'(SUM_W'(sq_a_q) + SUM_W'(sq_b_q));
			rem_q <= '0;
		end else if (state_q == H_REDUCE) begin
			x_q   <= x_q << RED_BITS;
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.key  = rem_q;

endmodule

// ===== rtl/core/silhouette_edge_toggle_hash_unit.sv =====
// Top level of the silhouette edge toggle hash: open-addressed edge set in one slot memory.
//
// Request channel (req_valid / req_stall / req): one command per request.
//   clear  - empties all 5987 slots and zeroes both counters, one result.
//   toggle - adds the edge if absent, removes it if present (either vertex order), reports full if no slot is free.
//   read   - returns one slot's contents; slots past the table read as empty.
//   command 3 is taken and dropped without a result.
// Result channel (rsp_valid / rsp_stall / rsp): one result per request, command 3 apart.
// One request is in flight at a time; req_stall is high while it is worked on.
// Steps from request accept to result valid:
//   toggle - hashing (square, sum, 9 reduction steps), then probes of a
//            memory read and a check/write each; one or two probes
//            on a lightly loaded table, up to 5987 when it is full.
//   read   - memory read, then result.  clear - all 5987 rows, one memory row per cycle.
// The probe loop rate is set by the single memory port: read a slot, then
// write it back or step 241 slots on.
// Reset: an asynchronous reset is followed by the same clearing pass over
// all 5987 slots; req_stall stays high until it is done.
// The result sits in an output register; while rsp_stall is high it holds,
// and the block waits on it at every probe check as well as before each result.
module silhouette_edge_toggle_hash_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  seth_pkg::edge_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output seth_pkg::edge_rsp_t rsp
);
	import seth_pkg::*;

	typedef enum logic [7:0] {
		S_SWEEP     = 8'b0000_0001,
		S_IDLE      = 8'b0000_0010,
		S_HASH      = 8'b0000_0100,
		S_PROBE_RD  = 8'b0000_1000,
		S_PROBE_CHK = 8'b0001_0000,
		S_READ_RD   = 8'b0010_0000,
		S_READ_OUT  = 8'b0100_0000,
		S_CLR_OUT   = 8'b1000_0000
	} state_t;

	state_t            state_q, state_d;
	edge_req_t         req_q;
	logic [SLOT_W-1:0] sweep_q, sweep_d;
	logic [SLOT_W-1:0] k_q, k_d;
	logic [SLOT_W-1:0] probe_q, probe_d;
	logic [CNT_W-1:0]  edges_q, edges_d;
	logic [COLL_W-1:0] coll_q, coll_d;
	logic              clr_emit_q, clr_emit_d;
	logic              rsp_valid_q;
	edge_rsp_t         rsp_q, rsp_d;
	logic              emit;

	logic              accept;
	logic              out_free;
	logic              hash_start;
	hash_rsp_t         hash_rsp;
	ram_req_t          ram_req;
	slot_entry_t       entry;
	logic              match;
	logic              slot_in_range;
	logic [REM_W-1:0]  k_step;
	logic [SLOT_W-1:0] k_next;

	assign req_stall  = (state_q != S_IDLE);
	assign accept     = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign hash_start = accept && (req.command == CMD_TOGGLE);

	seth_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (hash_start),
		.vertex_a (req.vertex_a),
		.vertex_b (req.vertex_b),
		.rsp      (hash_rsp)
	);

	seth_slot_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (entry)
	);

	// same undirected edge, either order
	assign match = (entry.first == req_q.vertex_a && entry.second == req_q.vertex_b) ||
	               (entry.first == req_q.vertex_b && entry.second == req_q.vertex_a);

	assign slot_in_range = (32'(req_q.slot) < 32'(TABLE_SIZE));

	// next probe slot, wrapping modulo the table size
	assign k_step = {1'b0, k_q} + REM_W'(STEP_MOD);
	assign k_next = (k_step >= REM_W'(TABLE_SIZE)) ?
	                SLOT_W'(k_step - REM_W'(TABLE_SIZE)) : SLOT_W'(k_step);

	// Memory port: sweep writes, probe reads, check write-back, slot reads.
	// A write and the following read of the same slot never share a cycle.
	always_comb begin
		ram_req = '0;
		case (state_q)
			S_SWEEP: begin
				ram_req.wr_en = 1'b1;
				ram_req.addr  = sweep_q;
			end
			S_PROBE_RD: begin
				ram_req.rd_en = 1'b1;
				ram_req.addr  = k_q;
			end
			S_PROBE_CHK: begin
				ram_req.addr = k_q;
				if (out_free) begin
					if (!entry.valid) begin
						ram_req.wr_en        = 1'b1;
						ram_req.wdata.valid  = 1'b1;
						ram_req.wdata.first  = req_q.vertex_a;
						ram_req.wdata.second = req_q.vertex_b;
					end else if (match) begin
						ram_req.wr_en = 1'b1;
					end
				end
			end
			S_READ_RD: begin
				ram_req.rd_en = slot_in_range;
				ram_req.addr  = SLOT_W'(req_q.slot);
			end
			default: ;
		endcase
	end

	// Sequencer: next state, counters and the result to load.
	always_comb begin
		state_d    = state_q;
		sweep_d    = sweep_q;
		k_d        = k_q;
		probe_d    = probe_q;
		edges_d    = edges_q;
		coll_d     = coll_q;
		clr_emit_d = clr_emit_q;
		emit       = 1'b0;
		rsp_d      = '0;
		case (state_q)
			S_SWEEP: begin
				sweep_d = sweep_q + 1'b1;
				if (sweep_q == SLOT_W'(TABLE_SIZE - 1)) begin
					sweep_d = '0;
					state_d = clr_emit_q ? S_CLR_OUT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (req.command)
						CMD_CLEAR: begin
							state_d    = S_SWEEP;
							clr_emit_d = 1'b1;
							edges_d    = '0;
							coll_d     = '0;
						end
						CMD_TOGGLE: state_d = S_HASH;
						CMD_READ:   state_d = S_READ_RD;
						default:    ;
					endcase
				end
			end
			S_HASH: begin
				if (hash_rsp.done) begin
					k_d     = hash_rsp.key;
					probe_d = '0;
					state_d = S_PROBE_RD;
				end
			end
			S_PROBE_RD: state_d = S_PROBE_CHK;
			S_PROBE_CHK: begin
				if (out_free) begin
					if (!entry.valid) begin
						emit             = 1'b1;
						rsp_d.status     = ST_ADDED;
						rsp_d.slot_index = SLOT_FIELD_W'(k_q);
						edges_d          = CNT_W'(edges_q + 1'b1);
						state_d          = S_IDLE;
					end else if (match) begin
						emit             = 1'b1;
						rsp_d.status     = ST_REMOVED;
						rsp_d.slot_index = SLOT_FIELD_W'(k_q);
						if (edges_q != '0) begin
							edges_d = edges_q - 1'b1;
						end
						state_d = S_IDLE;
					end else begin
						// foreign slot: count it, then step on or give up
						if (coll_q != '1) begin
							coll_d = coll_q + 1'b1;
						end
						if (probe_q == SLOT_W'(TABLE_SIZE - 1)) begin
							emit         = 1'b1;
							rsp_d.status = ST_FULL;
							state_d      = S_IDLE;
						end else begin
							k_d     = k_next;
							probe_d = probe_q + 1'b1;
							state_d = S_PROBE_RD;
						end
					end
				end
			end
			S_READ_RD: state_d = S_READ_OUT;
			S_READ_OUT: begin
				if (out_free) begin
					emit             = 1'b1;
					rsp_d.status     = ST_READ;
					rsp_d.slot_index = req_q.slot;
					if (slot_in_range && entry.valid) begin
						rsp_d.occupied = 1'b1;
						rsp_d.stored_a = entry.first;
						rsp_d.stored_b = entry.second;
					end
					state_d = S_IDLE;
				end
			end
			S_CLR_OUT: begin
				if (out_free) begin
					emit         = 1'b1;
					rsp_d.status = ST_CLEARED;
					clr_emit_d   = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		rsp_d.edge_count      = COUNT_FIELD_W'(edges_d);
		rsp_d.collision_total = coll_d;
	end

	// reset starts with a clearing pass that produces no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_q     <= '0;
			k_q         <= '0;
			probe_q     <= '0;
			edges_q     <= '0;
			coll_q      <= '0;
			clr_emit_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			sweep_q    <= sweep_d;
			k_q        <= k_d;
			probe_q    <= probe_d;
			edges_q    <= edges_d;
			coll_q     <= coll_d;
			clr_emit_q <= clr_emit_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/seth_checker.sv =====
// Port-level checks of the edge toggle hash results, bound to the top level.
module seth_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input seth_pkg::edge_rsp_t rsp
);
	import seth_pkg::*;

	// a stalled result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// only a slot read exposes stored vertices
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_READ |->
		!rsp.occupied && rsp.stored_a == '0 && rsp.stored_b == '0)
		else $error("non-read result carries slot contents");

	// clear reports zero counters and a zero slot index
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_CLEARED |->
		rsp.edge_count == '0 && rsp.collision_total == '0 && rsp.slot_index == '0)
		else $error("clear result with nonzero counters");

	// added or removed edges always land inside the table, with the edge count at most the table size
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_ADDED || rsp.status == ST_REMOVED) |->
		32'(rsp.slot_index) < 32'(TABLE_SIZE) && 32'(rsp.edge_count) <= 32'(TABLE_SIZE))
		else $error("toggle result slot or count out of range");

endmodule

bind silhouette_edge_toggle_hash_unit seth_checker u_seth_checker (.*);
